// ----- src/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
// Holds command and outcome codes, field widths and the inter-module structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

	// default configuration
	localparam int DEF_CAPACITY = 8;
	localparam int DEF_KEY_BITS = 64;

	// fixed field widths
	localparam int KEY_W   = 64;
	localparam int CNT_W   = 16;
	localparam int DELTA_W = 17;
	localparam int STAT_W  = 2;
	localparam int ENTRY_W = 4;
	localparam int CODE_W  = 3;

	// packed stream widths
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 88;

	typedef enum logic [CODE_W-1:0] {
		CMD_ADD    = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_FIND   = 3'd2,
		CMD_ADJUST = 3'd3,
		CMD_STATUS = 3'd4,
		CMD_LIST   = 3'd5
	} cmd_t;

	typedef enum logic [CODE_W-1:0] {
		OUT_OK      = 3'd0,
		OUT_FULL    = 3'd1,
		OUT_DUP     = 3'd2,
		OUT_MISSING = 3'd3,
		OUT_SHORT   = 3'd4,
		OUT_EMPTY   = 3'd5
	} outcome_t;

	// memory port controls from the sequencer to the store
	typedef struct packed {
		logic rd;
		logic rec_we;
		logic link_we;
	} store_ctl_t;

	// one result transaction
	typedef struct packed {
		outcome_t           outcome;
		logic [KEY_W-1:0]   record_key;
		logic [CNT_W-1:0]   count_level;
		logic [STAT_W-1:0]  record_status;
		logic [ENTRY_W-1:0] entry_count;
		logic               last;
	} result_t;

endpackage

`default_nettype wire

// ----- src/keyed_record_table_with_free_list_unit.sv -----
// Top level of the keyed record table: stream ports, output register.
// Instantiates krt_ctrl and krt_store; depends on krt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A pool of CAPACITY records (key, 16-bit count, 2-bit status) kept on a
// linked used list with new records at the head, and free slots on a free
// list. One command is worked at a time. A key search reads the record and
// link memories one list entry per cycle. A list command produces one
// result per cycle while the result side takes them. A result waits in the
// output register while the next command is accepted. No clearing pass
// follows reset.
module keyed_record_table_with_free_list_unit #(
	parameter int CAPACITY = krt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = krt_pkg::DEF_KEY_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// key[63:0], initial_count[79:64], count_change[96:80], status_code[98:97]
	input  wire logic [krt_pkg::S_TDATA_W-1:0]   s_tdata,
	// command[2:0]
	input  wire logic [krt_pkg::CODE_W-1:0]      s_tuser,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// record_key[63:0], count_level[79:64], record_status[81:80], entry_count[85:82]
	output logic      [krt_pkg::M_TDATA_W-1:0]   m_tdata,
	// outcome[2:0]
	output logic      [krt_pkg::CODE_W-1:0]      m_tuser,
	output logic                                 m_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready
);

	localparam int SW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int RW = KEY_BITS + krt_pkg::CNT_W + krt_pkg::STAT_W;

	krt_pkg::store_ctl_t ctl;
	krt_pkg::result_t    res;
	logic                res_valid;
	logic                res_ready;
	logic [SW-1:0]       rd_addr;
	logic [SW-1:0]       rec_waddr;
	logic [RW-1:0]       rec_wdata;
	logic [SW-1:0]       link_waddr;
	logic [LW-1:0]       link_wdata;
	logic [RW-1:0]       rec_rdata;
	logic [LW-1:0]       link_rdata;

	logic                          m_tvalid_q;
	logic [krt_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [krt_pkg::CODE_W-1:0]    m_tuser_q;
	logic                          m_tlast_q;

	krt_ctrl #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_key     (s_tdata[63:0]),
		.in_init    (s_tdata[79:64]),
		.in_delta   (s_tdata[96:80]),
		.in_status  (s_tdata[98:97]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.rec_waddr  (rec_waddr),
		.rec_wdata  (rec_wdata),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.rec_rdata  (rec_rdata),
		.link_rdata (link_rdata)
	);

	krt_store #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.rec_waddr  (rec_waddr),
		.rec_wdata  (rec_wdata),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.rec_rdata  (rec_rdata),
		.link_rdata (link_rdata)
	);

	// output register: takes a result whenever it is empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {2'b00, res.entry_count, res.record_status,
			              res.count_level, res.record_key};
			m_tuser_q <= res.outcome;
			m_tlast_q <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// ----- src/krt_store.sv -----
// Record memory and link memory of the table, both with registered synchronous read.
// Link entries not yet written read as their reset chain value (slot + 1).
// Depends on krt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module krt_store #(
	parameter int CAPACITY = krt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = krt_pkg::DEF_KEY_BITS,
	localparam int SW = $clog2(CAPACITY),
	localparam int LW = $clog2(CAPACITY + 1),
	localparam int RW = KEY_BITS + krt_pkg::CNT_W + krt_pkg::STAT_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire krt_pkg::store_ctl_t ctl,
	input  wire logic [SW-1:0]       rd_addr,
	input  wire logic [SW-1:0]       rec_waddr,
	input  wire logic [RW-1:0]       rec_wdata,
	input  wire logic [SW-1:0]       link_waddr,
	input  wire logic [LW-1:0]       link_wdata,
	output logic      [RW-1:0]       rec_rdata,
	output logic      [LW-1:0]       link_rdata
);

	logic [RW-1:0]       rec_mem_q  [CAPACITY];
	logic [LW-1:0]       link_mem_q [CAPACITY];
	logic [CAPACITY-1:0] link_vld_q;
	logic [RW-1:0]       rec_rdata_q;
	logic [LW-1:0]       link_rdata_q;

	// record memory: key, count, status
	always_ff @(posedge clk) begin
		if (ctl.rec_we) begin
			rec_mem_q[rec_waddr] <= rec_wdata;
		end
		if (ctl.rd) begin
			rec_rdata_q <= rec_mem_q[rd_addr];
		end
	end

	// link memory; unwritten entries return the reset chain
	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem_q[link_waddr] <= link_wdata;
		end
		if (ctl.rd) begin
			if (link_vld_q[rd_addr]) begin
				link_rdata_q <= link_mem_q[rd_addr];
			end else begin
				link_rdata_q <= LW'(rd_addr) + LW'(1);
			end
		end
	end

	// per-entry written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
		end else if (ctl.link_we) begin
			link_vld_q[link_waddr] <= 1'b1;
		end
	end

	assign rec_rdata  = rec_rdata_q;
	assign link_rdata = link_rdata_q;

endmodule

`default_nettype wire

// ----- src/krt_ctrl.sv -----
// Command sequencer: walks the used list, updates records and both lists.
// Drives the store ports and presents one result at a time.
// Depends on krt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module krt_ctrl #(
	parameter int CAPACITY = krt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = krt_pkg::DEF_KEY_BITS,
	localparam int SW = $clog2(CAPACITY),
	localparam int LW = $clog2(CAPACITY + 1),
	localparam int RW = KEY_BITS + krt_pkg::CNT_W + krt_pkg::STAT_W
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command transactions
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [krt_pkg::CODE_W-1:0]        in_cmd,
	input  wire logic [krt_pkg::KEY_W-1:0]         in_key,
	input  wire logic [krt_pkg::CNT_W-1:0]         in_init,
	input  wire logic signed [krt_pkg::DELTA_W-1:0] in_delta,
	input  wire logic [krt_pkg::STAT_W-1:0]        in_status,
	// result transactions
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output krt_pkg::result_t                       res,
	// store
	output krt_pkg::store_ctl_t                    ctl,
	output logic      [SW-1:0]                     rd_addr,
	output logic      [SW-1:0]                     rec_waddr,
	output logic      [RW-1:0]                     rec_wdata,
	output logic      [SW-1:0]                     link_waddr,
	output logic      [LW-1:0]                     link_wdata,
	input  wire logic [RW-1:0]                     rec_rdata,
	input  wire logic [LW-1:0]                     link_rdata
);

	localparam int CNT_W  = krt_pkg::CNT_W;
	localparam int STAT_W = krt_pkg::STAT_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
	localparam logic [LW-1:0] LAST_STEP = LW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_DEL,
		ST_LIST,
		ST_EMIT
	} state_t;

	state_t state_q;

	// list heads and fill level
	logic [LW-1:0] used_head_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] held_q;

	// walk position
	logic [LW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic [LW-1:0] steps_q;
	logic [LW-1:0] hit_link_q;

	// latched command
	krt_pkg::cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]            key_q;
	logic [CNT_W-1:0]               init_q;
	logic signed [krt_pkg::DELTA_W-1:0] delta_q;
	logic [STAT_W-1:0]              status_q;

	// record found by the search
	logic [KEY_BITS-1:0] rep_key_q;
	logic [CNT_W-1:0]    rep_count_q;
	logic [STAT_W-1:0]   rep_status_q;

	// pending single result
	krt_pkg::outcome_t   res_outcome_q;
	logic [KEY_BITS-1:0] res_key_q;
	logic [CNT_W-1:0]    res_count_q;
	logic [STAT_W-1:0]   res_status_q;

	logic                accept;
	logic                head_ok;
	logic                free_ok;
	logic                prev_ok;
	logic                nxt_ok;
	logic                key_hit;
	logic [KEY_BITS-1:0] rd_key;
	logic [CNT_W-1:0]    rd_count;
	logic [STAT_W-1:0]   rd_status;
	logic [krt_pkg::DELTA_W-1:0] mag;
	logic [CNT_W:0]      sum;
	logic                short_adj;
	logic [CNT_W-1:0]    new_count;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign head_ok = (used_head_q < NULL_LINK);
	assign free_ok = (free_head_q < NULL_LINK);
	assign prev_ok = (prev_q < NULL_LINK);

	// unpack the record read
	assign rd_status = rec_rdata[STAT_W-1:0];
	assign rd_count  = rec_rdata[STAT_W +: CNT_W];
	assign rd_key    = rec_rdata[RW-1 -: KEY_BITS];

	assign key_hit = (rd_key == key_q);
	// next link is a slot and the walk bound is not reached
	assign nxt_ok  = (link_rdata < NULL_LINK) && (steps_q < LAST_STEP);

	// count adjust with refusal below zero and saturation at the top
	assign mag       = ~delta_q + 1'b1;
	assign short_adj = delta_q[krt_pkg::DELTA_W-1] && (mag > {1'b0, rep_count_q});
	assign sum       = {1'b0, rep_count_q} + delta_q[CNT_W:0];
	always_comb begin
		if (delta_q[krt_pkg::DELTA_W-1]) begin
			new_count = rep_count_q - mag[CNT_W-1:0];
		end else if (sum[CNT_W]) begin
			new_count = '1;
		end else begin
			new_count = sum[CNT_W-1:0];
		end
	end

	// store port drive
	always_comb begin
		ctl        = '0;
		rd_addr    = '0;
		rec_waddr  = cur_q[SW-1:0];
		rec_wdata  = {rep_key_q, rep_count_q, rep_status_q};
		link_waddr = cur_q[SW-1:0];
		link_wdata = free_head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && head_ok) begin
					if ((in_cmd == krt_pkg::CMD_ADD && free_head_q < NULL_LINK)
					    || in_cmd == krt_pkg::CMD_DELETE || in_cmd == krt_pkg::CMD_FIND
					    || in_cmd == krt_pkg::CMD_ADJUST || in_cmd == krt_pkg::CMD_STATUS
					    || in_cmd == krt_pkg::CMD_LIST) begin
						ctl.rd  = 1'b1;
						rd_addr = used_head_q[SW-1:0];
					end
				end
			end
			ST_SCAN: begin
				if (!key_hit && nxt_ok) begin
					ctl.rd  = 1'b1;
					rd_addr = link_rdata[SW-1:0];
				end
			end
			ST_HIT: begin
				case (cmd_q)
					krt_pkg::CMD_DELETE: begin
						ctl.link_we = prev_ok;
						link_waddr  = prev_q[SW-1:0];
						link_wdata  = hit_link_q;
					end
					krt_pkg::CMD_ADJUST: begin
						ctl.rec_we = !short_adj;
						rec_wdata  = {rep_key_q, new_count, rep_status_q};
					end
					krt_pkg::CMD_STATUS: begin
						ctl.rec_we = 1'b1;
						rec_wdata  = {rep_key_q, rep_count_q, status_q};
					end
					default: begin
					end
				endcase
			end
			ST_ADD_RD: begin
				ctl.rd  = 1'b1;
				rd_addr = free_head_q[SW-1:0];
			end
			ST_ADD_WR: begin
				ctl.rec_we  = 1'b1;
				ctl.link_we = 1'b1;
				rec_waddr   = free_head_q[SW-1:0];
				rec_wdata   = {key_q, init_q, status_q};
				link_waddr  = free_head_q[SW-1:0];
				link_wdata  = used_head_q;
			end
			ST_DEL: begin
				ctl.link_we = 1'b1;
				link_waddr  = cur_q[SW-1:0];
				link_wdata  = free_head_q;
			end
			ST_LIST: begin
				if (res_ready && nxt_ok) begin
					ctl.rd  = 1'b1;
					rd_addr = link_rdata[SW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// result presentation
	always_comb begin
		res_valid         = (state_q == ST_EMIT) || (state_q == ST_LIST);
		res.entry_count   = krt_pkg::ENTRY_W'(held_q);
		if (state_q == ST_LIST) begin
			res.outcome       = krt_pkg::OUT_OK;
			res.record_key    = krt_pkg::KEY_W'(rd_key);
			res.count_level   = rd_count;
			res.record_status = rd_status;
			res.last          = !nxt_ok;
		end else begin
			res.outcome       = res_outcome_q;
			res.record_key    = krt_pkg::KEY_W'(res_key_q);
			res.count_level   = res_count_q;
			res.record_status = res_status_q;
			res.last          = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_head_q <= NULL_LINK;
			free_head_q <= '0;
			held_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= krt_pkg::cmd_t'(in_cmd);
						key_q    <= in_key[KEY_BITS-1:0];
						init_q   <= in_init;
						delta_q  <= in_delta;
						status_q <= in_status;
						cur_q    <= used_head_q;
						prev_q   <= NULL_LINK;
						steps_q  <= '0;
						res_key_q    <= '0;
						res_count_q  <= '0;
						res_status_q <= '0;
						case (in_cmd)
							krt_pkg::CMD_ADD: begin
								if (!free_ok) begin
									res_outcome_q <= krt_pkg::OUT_FULL;
									state_q       <= ST_EMIT;
								end else if (head_ok) begin
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_ADD_RD;
								end
							end
							krt_pkg::CMD_DELETE, krt_pkg::CMD_FIND,
							krt_pkg::CMD_ADJUST, krt_pkg::CMD_STATUS: begin
								if (head_ok) begin
									state_q <= ST_SCAN;
								end else begin
									res_outcome_q <= krt_pkg::OUT_MISSING;
									state_q       <= ST_EMIT;
								end
							end
							krt_pkg::CMD_LIST: begin
								if (head_ok) begin
									state_q <= ST_LIST;
								end else begin
									res_outcome_q <= krt_pkg::OUT_EMPTY;
									state_q       <= ST_EMIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				// one list entry per cycle
				ST_SCAN: begin
					if (key_hit) begin
						hit_link_q   <= link_rdata;
						rep_key_q    <= rd_key;
						rep_count_q  <= rd_count;
						rep_status_q <= rd_status;
						state_q      <= ST_HIT;
					end else if (nxt_ok) begin
						prev_q  <= cur_q;
						cur_q   <= link_rdata;
						steps_q <= steps_q + LW'(1);
					end else if (cmd_q == krt_pkg::CMD_ADD) begin
						state_q <= ST_ADD_RD;
					end else begin
						res_outcome_q <= krt_pkg::OUT_MISSING;
						state_q       <= ST_EMIT;
					end
				end
				// act on the record found
				ST_HIT: begin
					res_outcome_q <= krt_pkg::OUT_OK;
					res_key_q     <= rep_key_q;
					res_count_q   <= rep_count_q;
					res_status_q  <= rep_status_q;
					state_q       <= ST_EMIT;
					case (cmd_q)
						krt_pkg::CMD_ADD: begin
							res_outcome_q <= krt_pkg::OUT_DUP;
						end
						krt_pkg::CMD_DELETE: begin
							if (!prev_ok) begin
								used_head_q <= hit_link_q;
							end
							state_q <= ST_DEL;
						end
						krt_pkg::CMD_ADJUST: begin
							if (short_adj) begin
								res_outcome_q <= krt_pkg::OUT_SHORT;
							end else begin
								res_count_q <= new_count;
							end
						end
						krt_pkg::CMD_STATUS: begin
							res_status_q <= status_q;
						end
						default: begin
						end
					endcase
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_WR;
				end
				// link the new record at the head
				ST_ADD_WR: begin
					free_head_q   <= link_rdata;
					used_head_q   <= free_head_q;
					held_q        <= held_q + LW'(1);
					res_outcome_q <= krt_pkg::OUT_OK;
					res_key_q     <= key_q;
					res_count_q   <= init_q;
					res_status_q  <= status_q;
					state_q       <= ST_EMIT;
				end
				// return the slot to the free list
				ST_DEL: begin
					free_head_q <= cur_q;
					if (held_q != '0) begin
						held_q <= held_q - LW'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_LIST: begin
					if (res_ready) begin
						if (nxt_ok) begin
							cur_q   <= link_rdata;
							steps_q <= steps_q + LW'(1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/krt_checker.sv -----
// Port-level checks for the keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table_with_free_list_unit.
`timescale 1ns / 1ps
`default_nettype none

module krt_checker #(
	parameter int CAPACITY = krt_pkg::DEF_CAPACITY
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic [krt_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic [krt_pkg::CODE_W-1:0]    m_tuser,
	input wire logic                          m_tlast,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready
);

	// stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		                          && $stable(m_tlast))
		else $error("stalled result changed");

	// outcomes without a record report zero record fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == krt_pkg::OUT_FULL || m_tuser == krt_pkg::OUT_MISSING
		             || m_tuser == krt_pkg::OUT_EMPTY)
		|-> m_tdata[81:0] == '0)
		else $error("record fields set on a result without a record");

	// empty listing is a single final result with nothing held
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == krt_pkg::OUT_EMPTY |-> m_tlast && m_tdata[85:82] == '0)
		else $error("empty listing malformed");

	// fill level never exceeds the pool
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY > 15) || (m_tdata[85:82] <= 4'(CAPACITY)))
		else $error("entry count above capacity");

	// a table-full report only when every slot is held
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == krt_pkg::OUT_FULL
		|-> (CAPACITY > 15) || (m_tdata[85:82] == 4'(CAPACITY)))
		else $error("table full reported with free slots");

endmodule

bind keyed_record_table_with_free_list_unit krt_checker #(
	.CAPACITY (CAPACITY)
) u_krt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire

// ----- bench/keyed_record_table_with_free_list_unit_test.sv -----
// Testbench for keyed_record_table_with_free_list_unit: directed and random commands,
// results checked against an in-bench model of the record pool and its two lists.
// Depends on krt_pkg and the unit RTL.
`timescale 1ns / 1ps

module keyed_record_table_with_free_list_unit_test;

	localparam int CAPACITY  = krt_pkg::DEF_CAPACITY;
	localparam int NULL_SLOT = CAPACITY;
	localparam int RANDOM_ITEMS = 145;

	localparam int CODE_W    = krt_pkg::CODE_W;
	localparam int KEY_W     = krt_pkg::KEY_W;
	localparam int CNT_W     = krt_pkg::CNT_W;
	localparam int DELTA_W   = krt_pkg::DELTA_W;
	localparam int STAT_W    = krt_pkg::STAT_W;
	localparam int ENTRY_W   = krt_pkg::ENTRY_W;
	localparam int S_TDATA_W = krt_pkg::S_TDATA_W;
	localparam int M_TDATA_W = krt_pkg::M_TDATA_W;

	// command codes the unit ignores
	localparam logic [CODE_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CODE_W-1:0] CMD_SPARE_HI = 3'd7;

	// receiver hold-off windows, in cycles after reset
	localparam int HOLD_A_START = 400;
	localparam int HOLD_B_START = 3000;
	localparam int HOLD_LEN     = 200;

	typedef struct {
		logic [CODE_W-1:0]  cmd;
		logic [KEY_W-1:0]   key;
		logic [CNT_W-1:0]   init;
		logic [DELTA_W-1:0] delta;
		logic [STAT_W-1:0]  st;
	} command_t;

	typedef struct packed {
		logic [CODE_W-1:0]  outcome;
		logic [KEY_W-1:0]   key;
		logic [CNT_W-1:0]   count;
		logic [STAT_W-1:0]  status;
		logic [ENTRY_W-1:0] entries;
		logic               last;
	} report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CODE_W-1:0]    s_tuser = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [CODE_W-1:0]    m_tuser;
	logic                 m_tlast;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;

	command_t    pending_cmds[$];
	report_t     expected_reports[$];
	logic [63:0] key_pool[12];
	int          total_items;
	int          accepted_items = 0;
	int          fault_count = 0;
	logic        took_input = 1'b0;

	// model of the pool: record fields, links, list heads
	logic [KEY_W-1:0]  rec_key[CAPACITY];
	logic [CNT_W-1:0]  rec_count[CAPACITY];
	logic [STAT_W-1:0] rec_status[CAPACITY];
	int                next_slot[CAPACITY];
	int                used_top;
	int                free_top;
	int                held;

	keyed_record_table_with_free_list_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// walk the used list; returns the slot holding k or NULL_SLOT
	function automatic int search_used(input logic [KEY_W-1:0] k, output int prev);
		int cur;
		int p;
		int steps;
		cur = used_top;
		p = NULL_SLOT;
		steps = 0;
		prev = NULL_SLOT;
		while (cur < CAPACITY && steps < CAPACITY) begin
			if (rec_key[cur] == k) begin
				prev = p;
				return cur;
			end
			p = cur;
			cur = next_slot[cur];
			steps++;
		end
		return NULL_SLOT;
	endfunction

	function automatic void push_report(input logic [CODE_W-1:0] oc, input int slot,
			input bit fin);
		report_t r;
		r.outcome = oc;
		if (slot < CAPACITY) begin
			r.key = rec_key[slot];
			r.count = rec_count[slot];
			r.status = rec_status[slot];
		end else begin
			r.key = '0;
			r.count = '0;
			r.status = '0;
		end
		r.entries = 4'(held);
		r.last = fin;
		expected_reports.push_back(r);
	endfunction

	// apply one command to the model and queue the results it causes
	function automatic void table_apply(input logic [CODE_W-1:0] cmd,
			input logic [KEY_W-1:0] k, input logic [CNT_W-1:0] init,
			input logic signed [DELTA_W-1:0] delta, input logic [STAT_W-1:0] st);
		int slot;
		int prev;
		int dv;
		int sum;
		int n;
		int nxt;
		case (cmd)
			krt_pkg::CMD_ADD: begin
				if (free_top >= CAPACITY) begin
					push_report(krt_pkg::OUT_FULL, NULL_SLOT, 1'b1);
				end else begin
					slot = search_used(k, prev);
					if (slot < CAPACITY) begin
						push_report(krt_pkg::OUT_DUP, slot, 1'b1);
					end else begin
						slot = free_top;
						free_top = next_slot[slot];
						rec_key[slot] = k;
						rec_count[slot] = init;
						rec_status[slot] = st;
						next_slot[slot] = used_top;
						used_top = slot;
						held++;
						push_report(krt_pkg::OUT_OK, slot, 1'b1);
					end
				end
			end
			krt_pkg::CMD_DELETE: begin
				slot = search_used(k, prev);
				if (slot >= CAPACITY) begin
					push_report(krt_pkg::OUT_MISSING, NULL_SLOT, 1'b1);
				end else begin
					if (prev < CAPACITY)
						next_slot[prev] = next_slot[slot];
					else
						used_top = next_slot[slot];
					next_slot[slot] = free_top;
					free_top = slot;
					if (held > 0)
						held--;
					push_report(krt_pkg::OUT_OK, slot, 1'b1);
				end
			end
			krt_pkg::CMD_FIND: begin
				slot = search_used(k, prev);
				push_report((slot < CAPACITY) ? krt_pkg::OUT_OK : krt_pkg::OUT_MISSING,
					slot, 1'b1);
			end
			krt_pkg::CMD_ADJUST: begin
				slot = search_used(k, prev);
				dv = int'(delta);
				if (slot >= CAPACITY) begin
					push_report(krt_pkg::OUT_MISSING, NULL_SLOT, 1'b1);
				end else if (dv < 0 && -dv > int'(rec_count[slot])) begin
					push_report(krt_pkg::OUT_SHORT, slot, 1'b1);
				end else begin
					// positive changes saturate at the top of the count range
					sum = int'(rec_count[slot]) + dv;
					rec_count[slot] = (sum > 65535) ? 16'hFFFF : sum[15:0];
					push_report(krt_pkg::OUT_OK, slot, 1'b1);
				end
			end
			krt_pkg::CMD_STATUS: begin
				slot = search_used(k, prev);
				if (slot >= CAPACITY) begin
					push_report(krt_pkg::OUT_MISSING, NULL_SLOT, 1'b1);
				end else begin
					rec_status[slot] = st;
					push_report(krt_pkg::OUT_OK, slot, 1'b1);
				end
			end
			krt_pkg::CMD_LIST: begin
				if (used_top >= CAPACITY) begin
					push_report(krt_pkg::OUT_EMPTY, NULL_SLOT, 1'b1);
				end else begin
					slot = used_top;
					n = 0;
					while (slot < CAPACITY && n < CAPACITY) begin
						nxt = next_slot[slot];
						push_report(krt_pkg::OUT_OK, slot,
							nxt >= CAPACITY || n + 1 >= CAPACITY);
						n++;
						slot = nxt;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_cmd(input logic [CODE_W-1:0] cmd,
			input logic [KEY_W-1:0] k, input logic [CNT_W-1:0] init,
			input logic [DELTA_W-1:0] delta, input logic [STAT_W-1:0] st);
		command_t c;
		c.cmd = cmd;
		c.key = k;
		c.init = init;
		c.delta = delta;
		c.st = st;
		pending_cmds.push_back(c);
	endfunction

	// random command: mostly pool keys so that hits, duplicates and deletes occur
	function automatic void queue_random_cmd();
		int pick;
		int d;
		logic [CODE_W-1:0]  cmd;
		logic [KEY_W-1:0]   k;
		logic [CNT_W-1:0]   init;
		logic [DELTA_W-1:0] delta;
		pick = $urandom_range(0, 99);
		if (pick < 30)      cmd = krt_pkg::CMD_ADD;
		else if (pick < 45) cmd = krt_pkg::CMD_DELETE;
		else if (pick < 58) cmd = krt_pkg::CMD_FIND;
		else if (pick < 78) cmd = krt_pkg::CMD_ADJUST;
		else if (pick < 88) cmd = krt_pkg::CMD_STATUS;
		else if (pick < 96) cmd = krt_pkg::CMD_LIST;
		else                cmd = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
		if ($urandom_range(0, 99) < 85)
			k = key_pool[$urandom_range(0, 11)];
		else
			k = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: init = '0;
			1: init = 16'hFFFF;
			2: init = 16'($urandom_range(0, 20));
			default: init = 16'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0, 1: begin
				d = $urandom_range(0, 40);
				d = d - 20;
				delta = d[16:0];
			end
			2: delta = 17'h0FFFF;
			3: delta = 17'h10001;
			default: delta = 17'($urandom);
		endcase
		queue_cmd(cmd, k, init, delta, 2'($urandom));
	endfunction

	// driver: bursts of back-to-back transactions separated by random gaps
	always @(negedge clk) begin
		command_t c;
		static int burst_left = 8;
		static int gap_left = 0;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !took_input) begin
			// hold the offered transaction
		end else if (gap_left > 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (pending_cmds.size() > 0) begin
			c = pending_cmds.pop_front();
			s_tuser <= c.cmd;
			s_tdata <= {5'b0, c.st, c.delta, c.init, c.key};
			s_tvalid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 40);
				gap_left = $urandom_range(1, 10);
			end else begin
				burst_left--;
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// receiver: randomly chosen stall modes, plus two long hold-offs
	always @(negedge clk) begin
		logic rdy;
		static int rx_cycle = 0;
		static int rx_mode = 0;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = (rx_cycle % 4 == 0);
				default: rdy = ($urandom_range(0, 9) < 8);
			endcase
			if ((rx_cycle >= HOLD_A_START && rx_cycle < HOLD_A_START + HOLD_LEN) ||
					(rx_cycle >= HOLD_B_START && rx_cycle < HOLD_B_START + HOLD_LEN))
				rdy = 1'b0;
			m_tready <= rdy;
		end
	end

	// monitor: predict on each accepted command, check each accepted result
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (!arst_n) begin
			took_input <= 1'b0;
		end else begin
			took_input <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				accepted_items <= accepted_items + 1;
				table_apply(s_tuser, s_tdata[63:0], s_tdata[79:64], s_tdata[96:80],
					s_tdata[98:97]);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[63:0], m_tdata[79:64], m_tdata[81:80],
					m_tdata[85:82], m_tlast};
				if (expected_reports.size() == 0) begin
					fault_count++;
					$display("%0t: unexpected result transaction: expected none, %s %0d %s %h %s %0d",
						$time, "actual outcome", got.outcome, "key", got.key,
						"count", got.count);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						fault_count++;
						$display("%0t: mismatch: expected outcome %0d key %h count %0d %s",
							$time, want.outcome, want.key, want.count, "");
						$display("%0t:   expected status %0d entries %0d last %0d",
							$time, want.status, want.entries, want.last);
						$display("%0t:   actual outcome %0d key %h count %0d",
							$time, got.outcome, got.key, got.count);
						$display("%0t:   actual status %0d entries %0d last %0d",
							$time, got.status, got.entries, got.last);
					end
				end
			end
		end
	end

	initial begin
		// model reset state: all slots free and chained in order
		for (int i = 0; i < CAPACITY; i++) begin
			rec_key[i] = '0;
			rec_count[i] = '0;
			rec_status[i] = '0;
			next_slot[i] = i + 1;
		end
		used_top = NULL_SLOT;
		free_top = 0;
		held = 0;

		for (int i = 0; i < 10; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[10] = '0;
		key_pool[11] = '1;

		// directed: empty table, extremes of key, count and change, full table
		queue_cmd(krt_pkg::CMD_LIST,   '0, '0, '0, '0);
		queue_cmd(krt_pkg::CMD_FIND,   '0, '0, '0, '0);
		queue_cmd(CMD_SPARE_LO, '1, '1, '1, '1);
		queue_cmd(krt_pkg::CMD_ADD,    '0, '0, '0, 2'd0);
		queue_cmd(krt_pkg::CMD_ADD,    '1, 16'hFFFF, '0, 2'd3);
		queue_cmd(krt_pkg::CMD_ADD,    '1, 16'd5, '0, 2'd1);
		queue_cmd(krt_pkg::CMD_ADJUST, '1, '0, 17'h0FFFF, '0);
		queue_cmd(krt_pkg::CMD_ADJUST, '1, '0, 17'h10001, '0);
		queue_cmd(krt_pkg::CMD_ADJUST, '1, '0, 17'h1FFFF, '0);
		queue_cmd(krt_pkg::CMD_ADJUST, '0, '0, 17'h00000, '0);
		queue_cmd(krt_pkg::CMD_STATUS, '0, '0, '0, 2'd2);
		queue_cmd(krt_pkg::CMD_ADJUST, key_pool[0], '0, 17'd3, '0);
		queue_cmd(krt_pkg::CMD_STATUS, key_pool[0], '0, '0, 2'd1);
		queue_cmd(krt_pkg::CMD_DELETE, key_pool[0], '0, '0, '0);
		for (int i = 0; i < 6; i++)
			queue_cmd(krt_pkg::CMD_ADD, key_pool[i], 16'($urandom), '0, 2'(i));
		queue_cmd(krt_pkg::CMD_ADD,    key_pool[6], 16'd1, '0, 2'd1);
		queue_cmd(krt_pkg::CMD_LIST,   '0, '0, '0, '0);
		queue_cmd(krt_pkg::CMD_DELETE, '1, '0, '0, '0);
		queue_cmd(krt_pkg::CMD_DELETE, '0, '0, '0, '0);
		queue_cmd(CMD_SPARE_HI, key_pool[1], '0, '0, '0);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_random_cmd();
		total_items = pending_cmds.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_items < total_items || expected_reports.size() > 0)
			@(posedge clk);
		// let a trailing ignored command drain
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("PASS keyed_record_table_with_free_list_unit");
		else
			$display("FAIL keyed_record_table_with_free_list_unit");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("FAIL keyed_record_table_with_free_list_unit");
		$finish;
	end

endmodule
